[rtl/jh2d_pkg.sv]
// Shared types, command codes and constants of the joint histogram.
`timescale 1ns / 1ps
`default_nettype none
package jh2d_pkg;
	localparam int X_BINS_MAX_DEF = 256;
	localparam int Y_BINS_MAX_DEF = 256;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int DN_W = 32;
	localparam int SCALE_W = 32;
	localparam int BINREG_W = 9;
	localparam int IDX_W = 16;
	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_W = 16;

	localparam logic [CMD_W-1:0] CMD_ACCUM = 3'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ALARM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLR_ALARM = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_IDX = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLR_COUNT = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_X_BINS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_Y_BINS = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic signed [DN_W-1:0] x_dn;
		logic signed [DN_W-1:0] y_dn;
		logic x_special;
		logic y_special;
		logic [IDX_W-1:0] bin_index;
	} in_t;

	typedef struct packed {
		logic [VAL_W-1:0] count_value;
		logic found;
		logic [VAL_W-1:0] max_count;
	} out_t;

	typedef struct packed {
		logic signed [DN_W-1:0] x_min;
		logic signed [DN_W-1:0] x_max;
		logic [SCALE_W-1:0] x_scale;
		logic signed [DN_W-1:0] y_min;
		logic signed [DN_W-1:0] y_max;
		logic [SCALE_W-1:0] y_scale;
		logic [BINREG_W-1:0] x_bins;
		logic [BINREG_W-1:0] y_bins;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic hit;
	} op_ctrl_t;

	localparam int OP_CTRL_W = CMD_W + 1;
endpackage
`default_nettype wire

[rtl/joint_histogram_2d.sv]
// Top level of the two-dimensional joint histogram with its configuration registers.
// Value commands give one result each and pass through the front end's subtract, multiply
// and round sequence; a new item is taken only after the previous one has been queued.
// Read by index: the flat index is split by the 16-step divider, and no new item is taken
// until the divider is done and its result has been queued.
// Clear commands sweep a memory, one entry a cycle, over all of its entries.
// After reset both memories are swept the same way, and no item is accepted
// until the sweep ends; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module joint_histogram_2d #(
	parameter int X_BINS_MAX = jh2d_pkg::X_BINS_MAX_DEF,
	parameter int Y_BINS_MAX = jh2d_pkg::Y_BINS_MAX_DEF,
	parameter int COUNT_WIDTH = jh2d_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = jh2d_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input jh2d_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output jh2d_pkg::out_t out_data,
	input logic cfg_we,
	input logic [jh2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [jh2d_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import jh2d_pkg::*;

	localparam int AW = $clog2(X_BINS_MAX) + $clog2(Y_BINS_MAX);
	localparam int QW = OP_CTRL_W + AW;

	cfg_t cfg_q;
	logic back_ready;
	logic push;
	op_ctrl_t push_ctrl;
	logic [AW-1:0] push_addr;
	logic full;
	logic pop;
	logic empty;
	logic [QW-1:0] q_rdata;
	op_ctrl_t op_ctrl;
	logic [AW-1:0] op_addr;

	assign op_ctrl = q_rdata[QW-1:AW];
	assign op_addr = q_rdata[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min <= '0;
			cfg_q.x_max <= DN_W'(255);
			cfg_q.x_scale <= SCALE_W'(65536);
			cfg_q.y_min <= '0;
			cfg_q.y_max <= DN_W'(255);
			cfg_q.y_scale <= SCALE_W'(65536);
			cfg_q.x_bins <= BINREG_W'(256);
			cfg_q.y_bins <= BINREG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_MIN: cfg_q.x_min <= cfg_wdata;
				REG_X_MAX: cfg_q.x_max <= cfg_wdata;
				REG_X_SCALE: cfg_q.x_scale <= cfg_wdata;
				REG_Y_MIN: cfg_q.y_min <= cfg_wdata;
				REG_Y_MAX: cfg_q.y_max <= cfg_wdata;
				REG_Y_SCALE: cfg_q.y_scale <= cfg_wdata;
				REG_X_BINS: cfg_q.x_bins <= cfg_wdata[BINREG_W-1:0];
				REG_Y_BINS: cfg_q.y_bins <= cfg_wdata[BINREG_W-1:0];
				default: ;
			endcase
		end
	end

	jh2d_front #(.X_BINS_MAX(X_BINS_MAX), .Y_BINS_MAX(Y_BINS_MAX)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.enable(back_ready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push(push),
		.push_ctrl(push_ctrl),
		.push_addr(push_addr),
		.full(full)
	);

	jh2d_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({push_ctrl, push_addr}),
		.full(full),
		.pop(pop),
		.rdata(q_rdata),
		.empty(empty)
	);

	jh2d_back #(
		.X_BINS_MAX(X_BINS_MAX),
		.Y_BINS_MAX(Y_BINS_MAX),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.pop(pop),
		.op_ctrl(op_ctrl),
		.op_addr(op_addr),
		.ready(back_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);
endmodule
`default_nettype wire

[rtl/jh2d_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module jh2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/jh2d_fifo.sv]
// Short queue that decouples the classifying front from the memory back end.
`timescale 1ns / 1ps
`default_nettype none
module jh2d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
endmodule
`default_nettype wire

[rtl/jh2d_front.sv]
// Front end: accepts items, maps values to bins and splits flat indexes.
`timescale 1ns / 1ps
`default_nettype none
module jh2d_front #(
	parameter int X_BINS_MAX = jh2d_pkg::X_BINS_MAX_DEF,
	parameter int Y_BINS_MAX = jh2d_pkg::Y_BINS_MAX_DEF
) (
	input logic clk,
	input logic arst_n,
	input jh2d_pkg::cfg_t cfg,
	input logic enable,
	input logic in_valid,
	output logic in_ready,
	input jh2d_pkg::in_t in_data,
	output logic push,
	output jh2d_pkg::op_ctrl_t push_ctrl,
	output logic [$clog2(X_BINS_MAX)+$clog2(Y_BINS_MAX)-1:0] push_addr,
	input logic full
);
	import jh2d_pkg::*;

	localparam int XW = $clog2(X_BINS_MAX);
	localparam int YW = $clog2(Y_BINS_MAX);
	localparam int AW = XW + YW;
	localparam int NXR = $clog2(X_BINS_MAX + 1);
	localparam int NYR = $clog2(Y_BINS_MAX + 1);
	localparam int NXW = (NXR > BINREG_W) ? NXR : BINREG_W;
	localparam int NYW = (NYR > BINREG_W) ? NYR : BINREG_W;
	localparam int PROD_W = DN_W + SCALE_W;
	localparam int POS_W = PROD_W - FRAC_W;
	localparam int SW = $clog2(IDX_W);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL = 3'd1;
	localparam logic [2:0] F_MAP = 3'd2;
	localparam logic [2:0] F_DIV = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;

	logic [2:0] state_q;
	in_t item_q;
	logic [NXW-1:0] nx_q;
	logic [NYW-1:0] ny_q;
	logic [PROD_W-1:0] prodx_s1;
	logic [PROD_W-1:0] prody_s1;
	logic inx_s1;
	logic iny_s1;
	logic [NXW-1:0] rem_q;
	logic [IDX_W-1:0] quo_q;
	logic [SW-1:0] step_q;
	op_ctrl_t ctrl_q;
	logic [AW-1:0] addr_q;

	logic [NXW-1:0] nx_ext;
	logic [NYW-1:0] ny_ext;
	logic [NXW-1:0] nx_now;
	logic [NYW-1:0] ny_now;
	logic [DN_W:0] xdiff;
	logic [DN_W:0] ydiff;
	logic inx;
	logic iny;
	logic [PROD_W-1:0] xsum;
	logic [PROD_W-1:0] ysum;
	logic [POS_W-1:0] posx;
	logic [POS_W-1:0] posy;
	logic [NXW:0] trial;
	logic trial_ge;
	logic [NXW-1:0] nrem;
	logic [IDX_W-1:0] nquo;
	logic accept;

	assign nx_ext = NXW'(cfg.x_bins);
	assign ny_ext = NYW'(cfg.y_bins);
	assign nx_now = (nx_ext > NXW'(X_BINS_MAX)) ? NXW'(X_BINS_MAX) : nx_ext;
	assign ny_now = (ny_ext > NYW'(Y_BINS_MAX)) ? NYW'(Y_BINS_MAX) : ny_ext;

	assign in_ready = (state_q == F_IDLE) && enable;
	assign accept = in_valid && in_ready;

	assign xdiff = {item_q.x_dn[DN_W-1], item_q.x_dn} - {cfg.x_min[DN_W-1], cfg.x_min};
	assign ydiff = {item_q.y_dn[DN_W-1], item_q.y_dn} - {cfg.y_min[DN_W-1], cfg.y_min};
	assign inx = !item_q.x_special && ($signed(item_q.x_dn) >= $signed(cfg.x_min))
		&& ($signed(item_q.x_dn) <= $signed(cfg.x_max));
	assign iny = !item_q.y_special && ($signed(item_q.y_dn) >= $signed(cfg.y_min))
		&& ($signed(item_q.y_dn) <= $signed(cfg.y_max));

	assign xsum = prodx_s1 + PROD_W'(1 << (FRAC_W - 1));
	assign ysum = prody_s1 + PROD_W'(1 << (FRAC_W - 1));
	assign posx = xsum[PROD_W-1:FRAC_W];
	assign posy = ysum[PROD_W-1:FRAC_W];

	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign trial_ge = (trial >= {1'b0, nx_q});
	assign nrem = trial_ge ? NXW'(trial - {1'b0, nx_q}) : trial[NXW-1:0];
	assign nquo = {quo_q[IDX_W-2:0], trial_ge};

	assign push = (state_q == F_PUSH) && !full;
	assign push_ctrl = ctrl_q;
	assign push_addr = addr_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			nx_q <= nx_now;
			ny_q <= ny_now;
		end
		if (state_q == F_MUL) begin
			prodx_s1 <= PROD_W'(xdiff[DN_W-1:0]) * PROD_W'(cfg.x_scale);
			prody_s1 <= PROD_W'(ydiff[DN_W-1:0]) * PROD_W'(cfg.y_scale);
			inx_s1 <= inx;
			iny_s1 <= iny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ctrl_q <= '0;
			addr_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						ctrl_q.cmd <= in_data.command;
						ctrl_q.hit <= 1'b0;
						addr_q <= '0;
						unique case (in_data.command) inside
							CMD_ACCUM, CMD_QUERY, CMD_ALARM: begin
								state_q <= F_MUL;
							end
							CMD_READ_IDX: begin
								rem_q <= '0;
								quo_q <= in_data.bin_index;
								step_q <= '0;
								state_q <= (nx_now == '0) ? F_PUSH : F_DIV;
							end
							default: begin
								state_q <= F_PUSH;
							end
						endcase
					end
				end
				F_MUL: begin
					state_q <= F_MAP;
				end
				F_MAP: begin
					ctrl_q.hit <= inx_s1 && iny_s1 && (posx < POS_W'(nx_q))
						&& (posy < POS_W'(ny_q));
					addr_q <= {posy[YW-1:0], posx[XW-1:0]};
					state_q <= F_PUSH;
				end
				F_DIV: begin
					rem_q <= nrem;
					quo_q <= nquo;
					step_q <= step_q + 1'b1;
					if (step_q == SW'(IDX_W - 1)) begin
						ctrl_q.hit <= (nquo < IDX_W'(ny_q));
						addr_q <= {nquo[YW-1:0], nrem[XW-1:0]};
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/jh2d_back.sv]
// Back end: updates and reads the count and alarm memories, keeps the maximum.
`timescale 1ns / 1ps
`default_nettype none
module jh2d_back #(
	parameter int X_BINS_MAX = jh2d_pkg::X_BINS_MAX_DEF,
	parameter int Y_BINS_MAX = jh2d_pkg::Y_BINS_MAX_DEF,
	parameter int COUNT_WIDTH = jh2d_pkg::COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	output logic pop,
	input jh2d_pkg::op_ctrl_t op_ctrl,
	input logic [$clog2(X_BINS_MAX)+$clog2(Y_BINS_MAX)-1:0] op_addr,
	output logic ready,
	output logic out_valid,
	input logic out_ready,
	output jh2d_pkg::out_t out_data
);
	import jh2d_pkg::*;

	localparam int AW = $clog2(X_BINS_MAX) + $clog2(Y_BINS_MAX);
	localparam int DEPTH = 1 << AW;
	localparam logic [COUNT_WIDTH-1:0] LIMIT = {COUNT_WIDTH{1'b1}};

	localparam logic [1:0] B_CLR = 2'd0;
	localparam logic [1:0] B_IDLE = 2'd1;
	localparam logic [1:0] B_RD = 2'd2;

	logic [1:0] state_q;
	logic clr_cnt_q;
	logic clr_alm_q;
	logic res_pend_q;
	logic [AW-1:0] sweep_q;
	op_ctrl_t ctrl_q;
	logic [AW-1:0] addr_q;
	logic [COUNT_WIDTH-1:0] largest_q;
	logic out_valid_q;
	out_t out_q;

	logic [COUNT_WIDTH-1:0] cnt_rd;
	logic [0:0] alm_rd;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic cnt_we;
	logic alm_we;
	logic [AW-1:0] waddr;
	logic [COUNT_WIDTH-1:0] cnt_wdata;
	logic [0:0] alm_wdata;
	logic [COUNT_WIDTH-1:0] rd_value;
	logic sweep_last;

	assign ready = (state_q != B_CLR) || res_pend_q;
	assign pop = (state_q == B_IDLE) && !empty && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign sweep_last = (sweep_q == {AW{1'b1}});

	assign cnt_new = (cnt_rd == LIMIT) ? cnt_rd : cnt_rd + 1'b1;
	assign cnt_we = ((state_q == B_CLR) && clr_cnt_q)
		|| ((state_q == B_RD) && (ctrl_q.cmd == CMD_ACCUM));
	assign alm_we = ((state_q == B_CLR) && clr_alm_q)
		|| ((state_q == B_RD) && (ctrl_q.cmd == CMD_ALARM));
	assign waddr = (state_q == B_CLR) ? sweep_q : addr_q;
	assign cnt_wdata = (state_q == B_CLR) ? '0 : cnt_new;
	assign alm_wdata = (state_q == B_CLR) ? 1'b0 : 1'b1;

	always_comb begin
		case (ctrl_q.cmd)
			CMD_ACCUM: rd_value = cnt_new;
			CMD_QUERY: rd_value = alm_rd[0] ? largest_q : cnt_rd;
			CMD_ALARM: rd_value = largest_q;
			default: rd_value = cnt_rd;
		endcase
	end

	jh2d_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_cnt_ram (
		.clk(clk),
		.we(cnt_we),
		.waddr(waddr),
		.wdata(cnt_wdata),
		.raddr(op_addr),
		.rdata(cnt_rd)
	);

	jh2d_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_alm_ram (
		.clk(clk),
		.we(alm_we),
		.waddr(waddr),
		.wdata(alm_wdata),
		.raddr(op_addr),
		.rdata(alm_rd)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q <= op_addr;
		end
		if (state_q == B_RD) begin
			out_q.count_value <= VAL_W'(rd_value);
			out_q.found <= 1'b1;
			out_q.max_count <= ((ctrl_q.cmd == CMD_ACCUM) && (cnt_new > largest_q))
				? VAL_W'(cnt_new) : VAL_W'(largest_q);
		end else if ((state_q == B_CLR) && sweep_last) begin
			out_q.count_value <= '0;
			out_q.found <= 1'b0;
			out_q.max_count <= VAL_W'(largest_q);
		end else if (pop && !op_ctrl.hit) begin
			out_q.count_value <= '0;
			out_q.found <= 1'b0;
			out_q.max_count <= (op_ctrl.cmd == CMD_CLR_COUNT) ? '0 : VAL_W'(largest_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_cnt_q <= 1'b1;
			clr_alm_q <= 1'b1;
			res_pend_q <= 1'b0;
			sweep_q <= '0;
			ctrl_q <= '0;
			largest_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						clr_cnt_q <= 1'b0;
						clr_alm_q <= 1'b0;
						res_pend_q <= 1'b0;
						out_valid_q <= res_pend_q;
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop) begin
						ctrl_q <= op_ctrl;
						if (op_ctrl.hit) begin
							state_q <= B_RD;
						end else begin
							unique case (op_ctrl.cmd)
								CMD_CLR_ALARM: begin
									clr_alm_q <= 1'b1;
									res_pend_q <= 1'b1;
									sweep_q <= '0;
									state_q <= B_CLR;
								end
								CMD_CLR_COUNT: begin
									clr_cnt_q <= 1'b1;
									res_pend_q <= 1'b1;
									sweep_q <= '0;
									largest_q <= '0;
									state_q <= B_CLR;
								end
								default: begin
									out_valid_q <= 1'b1;
								end
							endcase
						end
					end
				end
				B_RD: begin
					if ((ctrl_q.cmd == CMD_ACCUM) && (cnt_new > largest_q)) begin
						largest_q <= cnt_new;
					end
					out_valid_q <= 1'b1;
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_valid_q) else $error("operation started while a result waits");
	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLR) |-> !pop) else $error("operation taken during a clearing sweep");
	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_RD) && (ctrl_q.cmd == CMD_ACCUM)) |=> (largest_q >= $past(largest_q)))
		else $error("largest count dropped on an accumulate");
endmodule
`default_nettype wire
